>>> design/tcg_pkg.sv
`default_nettype none

package tcg_pkg;

    // field widths
    localparam int CODE_W  = 16;
    localparam int MULT_W  = 7;
    localparam int TIME_W  = 32;
    localparam int TEMP_W  = 10;
    localparam int TGT_W   = 8;
    localparam int HYST_W  = 5;
    localparam int HOLD_W  = 16;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 16;

    // register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_TARGET  = 3'd0;
    localparam logic [IDX_W-1:0] REG_HYST    = 3'd1;
    localparam logic [IDX_W-1:0] REG_MAXMULT = 3'd2;
    localparam logic [IDX_W-1:0] REG_MINMULT = 3'd3;
    localparam logic [IDX_W-1:0] REG_HOLDOFF = 3'd4;

    // reset values
    localparam logic signed [TGT_W-1:0] TARGET_RST  = 8'sd75;
    localparam logic [HYST_W-1:0]       HYST_RST    = 5'd3;
    localparam logic [MULT_W-1:0]       MAXMULT_RST = 7'd125;
    localparam logic [MULT_W-1:0]       MINMULT_RST = 7'd1;
    localparam logic [HOLD_W-1:0]       HOLDOFF_RST = 16'd1;

    // sensor codes that mean no reading
    localparam logic [CODE_W-1:0] CODE_ZERO     = 16'h0000;
    localparam logic [CODE_W-1:0] CODE_ALL_ONES = 16'hFFFF;

    typedef struct packed {
        logic signed [TGT_W-1:0] target_temp;
        logic [HYST_W-1:0]       hysteresis;
        logic [MULT_W-1:0]       max_mult;
        logic [MULT_W-1:0]       min_mult;
        logic [HOLD_W-1:0]       holdoff_ms;
    } t_cfg;

    typedef struct packed {
        logic [MULT_W-1:0] cool_ceiling;
        logic [TIME_W-1:0] last_cut_time;
        logic              cut_seen;
    } t_state;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_c;
        logic                     reading_valid;
        logic [MULT_W-1:0]        new_mult;
        logic                     clock_lowered;
        logic [MULT_W-1:0]        cool_max_mult;
    } t_result;

endpackage

`default_nettype wire

>>> design/tcg_ifs.sv
`default_nettype none

// sensor reading channel
interface tcg_in_if
    import tcg_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] sensor_code;
    logic [MULT_W-1:0] current_mult;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output sensor_code, output current_mult, output now_ms,
                    input ready);
    modport sink (input valid, input sensor_code, input current_mult, input now_ms,
                  output ready);
endinterface

// governor result channel
interface tcg_out_if
    import tcg_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temp_c;
    logic                     reading_valid;
    logic [MULT_W-1:0]        new_mult;
    logic                     clock_lowered;
    logic [MULT_W-1:0]        cool_max_mult;

    modport source (output valid, output temp_c, output reading_valid, output new_mult,
                    output clock_lowered, output cool_max_mult, input ready);
    modport sink (input valid, input temp_c, input reading_valid, input new_mult,
                  input clock_lowered, input cool_max_mult, output ready);
endinterface

// register write channel
interface tcg_cfg_if
    import tcg_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/tcg_cfg.sv
`default_nettype none

module tcg_cfg
    import tcg_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    tcg_cfg_if.sink     i_cfg,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // writes are always taken
    assign i_cfg.ready = 1'b1;

    // register decode, unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_TARGET:  n_cfg.target_temp = $signed(i_cfg.data[TGT_W-1:0]);
                REG_HYST:    n_cfg.hysteresis  = i_cfg.data[HYST_W-1:0];
                REG_MAXMULT: n_cfg.max_mult    = i_cfg.data[MULT_W-1:0];
                REG_MINMULT: n_cfg.min_mult    = i_cfg.data[MULT_W-1:0];
                REG_HOLDOFF: n_cfg.holdoff_ms  = i_cfg.data[HOLD_W-1:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_temp <= TARGET_RST;
            r_cfg.hysteresis  <= HYST_RST;
            r_cfg.max_mult    <= MAXMULT_RST;
            r_cfg.min_mult    <= MINMULT_RST;
            r_cfg.holdoff_ms  <= HOLDOFF_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> design/tcg_eval.sv
`default_nettype none

module tcg_eval
    import tcg_pkg::*;
(
    input  wire t_cfg         i_cfg,
    input  wire t_state       i_state,
    input  wire [CODE_W-1:0]  i_sensor_code,
    input  wire [MULT_W-1:0]  i_current_mult,
    input  wire [TIME_W-1:0]  i_now_ms,
    output t_result           o_result,
    output t_state            o_state
);

    logic                      valid;
    logic                      neg;
    logic signed [CODE_W-3:0]  fix_val;
    logic [CODE_W-3:0]         fix_abs;
    logic [CODE_W-2:0]         rnd_sum;
    logic [TEMP_W-2:0]         mag;
    logic signed [TEMP_W-1:0]  temp;
    logic signed [TEMP_W:0]    temp_x;
    logic signed [TEMP_W:0]    hi_lim;
    logic signed [TEMP_W:0]    lo_lim;
    logic signed [TEMP_W:0]    tgt_x;
    logic [TIME_W-1:0]         elapsed;
    logic                      cut_ok;
    logic [MULT_W-1:0]         newm;
    logic                      lowered;

    // reading check and rounding to whole degrees, half away from zero
    always_comb begin
        valid   = (i_sensor_code != CODE_ZERO) && (i_sensor_code != CODE_ALL_ONES);
        neg     = i_sensor_code[CODE_W-1];
        fix_val = $signed(i_sensor_code[CODE_W-1:2]);
        fix_abs = neg ? (CODE_W-2)'(-fix_val) : fix_val;
        rnd_sum = {1'b0, fix_abs} + (CODE_W-1)'(16);
        mag     = rnd_sum[CODE_W-3:5];
        temp    = neg ? TEMP_W'(-$signed({1'b0, mag})) : $signed({1'b0, mag});
    end

    // thresholds around the target
    always_comb begin
        temp_x  = (TEMP_W+1)'(temp);
        tgt_x   = (TEMP_W+1)'(i_cfg.target_temp);
        hi_lim  = tgt_x + $signed({{(TEMP_W+1-HYST_W){1'b0}}, i_cfg.hysteresis});
        lo_lim  = tgt_x - $signed({{(TEMP_W+1-HYST_W){1'b0}}, i_cfg.hysteresis});
        elapsed = i_now_ms - i_state.last_cut_time;
        cut_ok  = !i_state.cut_seen || (elapsed >= {{(TIME_W-HOLD_W){1'b0}}, i_cfg.holdoff_ms});
    end

    // multiplier and ceiling update
    always_comb begin
        o_state = i_state;
        newm    = i_current_mult;
        lowered = 1'b0;
        if (valid) begin
            if (temp_x > hi_lim) begin
                if (cut_ok) begin
                    o_state.last_cut_time = i_now_ms;
                    o_state.cut_seen      = 1'b1;
                    if (i_current_mult > i_cfg.min_mult) begin
                        newm    = i_current_mult - MULT_W'(1);
                        lowered = 1'b1;
                    end
                    o_state.cool_ceiling = newm;
                end
            end else if ((i_state.cool_ceiling < i_cfg.max_mult) && (temp_x < tgt_x)) begin
                if (temp_x < lo_lim) begin
                    o_state.cool_ceiling = i_cfg.max_mult;
                end else if (i_current_mult == i_state.cool_ceiling) begin
                    o_state.cool_ceiling = i_state.cool_ceiling + MULT_W'(1);
                end
            end
        end
        o_result.temp_c        = valid ? temp : '0;
        o_result.reading_valid = valid;
        o_result.new_mult      = newm;
        o_result.clock_lowered = lowered;
        o_result.cool_max_mult = o_state.cool_ceiling;
    end

endmodule

`default_nettype wire

>>> design/thermal_clock_governor.sv
// Thermal clock governor. Each transaction on the input channel carries one raw sensor
// word, the multiplier the clock runs at and the millisecond time; exactly one result
// transaction follows, in order. A reading is registered on entry, evaluated by one level
// of compare-and-update logic against the cool ceiling, last-cut time and cut flag, and
// registered again on exit. A new reading is taken every cycle unless the result side
// stalls; throughput is set only by how fast the result side takes results. Sensor words
// 0 and 0xFFFF are invalid and leave the state alone. Registers are written through the
// configuration channel (always ready); the user must write only while no reading is in
// flight (not enforced). A write to max_mult does not move the current cool ceiling.
`default_nettype none

module thermal_clock_governor
    import tcg_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    tcg_cfg_if.sink   i_cfg,
    tcg_in_if.sink    i_in,
    tcg_out_if.source o_out
);

    t_cfg              cfg;
    t_state            r_state;
    t_state            n_state;
    t_result           result;
    t_result           r_out;
    logic              r_in_vld;
    logic              r_out_vld;
    logic [CODE_W-1:0] r_in_code;
    logic [MULT_W-1:0] r_in_mult;
    logic [TIME_W-1:0] r_in_now;
    logic              out_free;
    logic              advance;
    logic              in_take;

    tcg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    tcg_eval u_eval (
        .i_cfg          (cfg),
        .i_state        (r_state),
        .i_sensor_code  (r_in_code),
        .i_current_mult (r_in_mult),
        .i_now_ms       (r_in_now),
        .o_result       (result),
        .o_state        (n_state)
    );

    // flow control between input and result registers
    assign out_free   = !r_out_vld || o_out.ready;
    assign advance    = r_in_vld && out_free;
    assign i_in.ready = !r_in_vld || out_free;
    assign in_take    = i_in.valid && i_in.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_code <= i_in.sensor_code;
            r_in_mult <= i_in.current_mult;
            r_in_now  <= i_in.now_ms;
        end
    end

    // governor state moves once per evaluated reading
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.cool_ceiling  <= MAXMULT_RST;
            r_state.last_cut_time <= '0;
            r_state.cut_seen      <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.temp_c        = r_out.temp_c;
    assign o_out.reading_valid = r_out.reading_valid;
    assign o_out.new_mult      = r_out.new_mult;
    assign o_out.clock_lowered = r_out.clock_lowered;
    assign o_out.cool_max_mult = r_out.cool_max_mult;

endmodule

`default_nettype wire

>>> verif/tb_thermal_clock_governor.sv
`timescale 1ns / 100ps

module tb_thermal_clock_governor
    import tcg_pkg::*;
;

    localparam int N_REGS       = 5;
    localparam int N_DIR        = 23;
    localparam int N_PHASES     = 10;
    localparam int PHASE_ITEMS  = 170;
    localparam int MAX_GAP      = 18;
    localparam int STALL_AT     = 500;
    localparam int STALL_CYCLES = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int WDOG_LIMIT   = 2000;

    logic i_clk;
    logic i_rst_n;

    tcg_cfg_if cfg_if ();
    tcg_in_if  in_if ();
    tcg_out_if out_if ();

    thermal_clock_governor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // directed readings, expected result typed in where typed_exp is set
    typedef struct packed {
        logic [CODE_W-1:0]        code;
        logic [MULT_W-1:0]        mult;
        logic [TIME_W-1:0]        now;
        logic                     typed_exp;
        logic signed [TEMP_W-1:0] temp_c;
        logic                     reading_valid;
        logic [MULT_W-1:0]        new_mult;
        logic                     clock_lowered;
        logic [MULT_W-1:0]        cool_max_mult;
    } t_dir_row;

    t_dir_row dir_rows [N_DIR] = '{
        // invalid codes, then tiny valid codes after reset
        '{16'h0000, 7'd50,  32'd0,          1'b1, 10'sd0,    1'b0, 7'd50,  1'b0, 7'd125},
        '{16'hFFFF, 7'd127, 32'hFFFF_FFFF,  1'b1, 10'sd0,    1'b0, 7'd127, 1'b0, 7'd125},
        '{16'h0001, 7'd64,  32'd5,          1'b1, 10'sd0,    1'b1, 7'd64,  1'b0, 7'd125},
        '{16'hFFFE, 7'd64,  32'd6,          1'b1, 10'sd0,    1'b1, 7'd64,  1'b0, 7'd125},
        // hottest code makes the first cut
        '{16'h7FFC, 7'd127, 32'd100,        1'b1, 10'sd256,  1'b1, 7'd126, 1'b1, 7'd126},
        // coldest code, ceiling above max_mult stays
        '{16'h8000, 7'd10,  32'd100,        1'b1, -10'sd256, 1'b1, 7'd10,  1'b0, 7'd126},
        // hot but held off
        '{16'h3200, 7'd126, 32'd100,        1'b1, 10'sd100,  1'b1, 7'd126, 1'b0, 7'd126},
        // cut at the floor keeps the multiplier
        '{16'h3200, 7'd1,   32'd101,        1'b1, 10'sd100,  1'b1, 7'd1,   1'b0, 7'd1},
        // well below target restores the ceiling
        '{16'h0004, 7'd40,  32'd102,        1'b1, 10'sd0,    1'b1, 7'd40,  1'b0, 7'd125},
        // cuts across the time wrap
        '{16'h3200, 7'd60,  32'hFFFF_FFFF,  1'b0, '0, '0, '0, '0, '0},
        '{16'h3200, 7'd59,  32'd0,          1'b0, '0, '0, '0, '0, '0},
        // inside the band: raise by one only when running at the ceiling
        '{16'h2480, 7'd58,  32'd2,          1'b0, '0, '0, '0, '0, '0},
        '{16'h2480, 7'd58,  32'd3,          1'b0, '0, '0, '0, '0, '0},
        '{16'h2440, 7'd59,  32'd4,          1'b0, '0, '0, '0, '0, '0},
        '{16'h243C, 7'd60,  32'd5,          1'b0, '0, '0, '0, '0, '0},
        // at target and at target plus hysteresis, then just above
        '{16'h2580, 7'd61,  32'd6,          1'b0, '0, '0, '0, '0, '0},
        '{16'h2700, 7'd61,  32'd7,          1'b0, '0, '0, '0, '0, '0},
        '{16'h2740, 7'd61,  32'd8,          1'b0, '0, '0, '0, '0, '0},
        // negative halves round away from zero, then both extreme codes with their low bits set
        '{16'hFFC0, 7'd60,  32'd9,          1'b0, '0, '0, '0, '0, '0},
        '{16'hFFC4, 7'd60,  32'd10,         1'b0, '0, '0, '0, '0, '0},
        '{16'hFFC3, 7'd60,  32'd11,         1'b0, '0, '0, '0, '0, '0},
        '{16'h7FFF, 7'd127, 32'd12,         1'b0, '0, '0, '0, '0, '0},
        '{16'h8003, 7'd127, 32'd13,         1'b0, '0, '0, '0, '0, '0}
    };

    t_cfg    gov_cfg;
    t_state  gov_st;
    t_result pending_results [$];

    logic [MULT_W-1:0] clock_mult;
    logic [TIME_W-1:0] clock_ms;
    bit send_quiet;
    bit take_quiet;
    int n_sent;
    int n_invalid;
    int n_cuts;
    int n_taken;
    int n_cfg_writes;
    int n_errors;
    int idle_cycles;

    // clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // expected governor decision for one reading, advances the predicted state
    function automatic t_result govern_reading(input logic [CODE_W-1:0] code,
                                               input logic [MULT_W-1:0] cur,
                                               input logic [TIME_W-1:0] now);
        t_result res;
        int raw;
        int q;
        int deg;
        int tgt;
        int hy;
        logic [TIME_W-1:0] elapsed;
        res.temp_c        = '0;
        res.reading_valid = 1'b0;
        res.new_mult      = cur;
        res.clock_lowered = 1'b0;
        if (code != CODE_ZERO && code != CODE_ALL_ONES) begin
            raw = int'($signed(code));
            q   = raw >>> 2;
            deg = (q < 0) ? -((16 - q) >>> 5) : ((q + 16) >>> 5);
            tgt = int'($signed(gov_cfg.target_temp));
            hy  = int'(gov_cfg.hysteresis);
            res.reading_valid = 1'b1;
            res.temp_c        = TEMP_W'(deg);
            elapsed           = now - gov_st.last_cut_time;
            if (deg > tgt + hy) begin
                // hot: cut once the hold-off has run out
                if (!gov_st.cut_seen || elapsed >= TIME_W'(gov_cfg.holdoff_ms)) begin
                    gov_st.last_cut_time = now;
                    gov_st.cut_seen      = 1'b1;
                    if (cur > gov_cfg.min_mult) begin
                        res.new_mult      = cur - 1'b1;
                        res.clock_lowered = 1'b1;
                    end
                    gov_st.cool_ceiling = res.new_mult;
                end
            end else if (gov_st.cool_ceiling < gov_cfg.max_mult && deg < tgt) begin
                // cool: restore well below target, creep up inside the band
                if (deg < tgt - hy)
                    gov_st.cool_ceiling = gov_cfg.max_mult;
                else if (cur == gov_st.cool_ceiling)
                    gov_st.cool_ceiling = gov_st.cool_ceiling + 1'b1;
            end
        end
        res.cool_max_mult = gov_st.cool_ceiling;
        return res;
    endfunction

    function automatic void apply_reg_write(input logic [IDX_W-1:0] idx,
                                            input logic [DATA_W-1:0] data);
        case (idx)
            REG_TARGET:  gov_cfg.target_temp = data[TGT_W-1:0];
            REG_HYST:    gov_cfg.hysteresis  = data[HYST_W-1:0];
            REG_MAXMULT: gov_cfg.max_mult    = data[MULT_W-1:0];
            REG_MINMULT: gov_cfg.min_mult    = data[MULT_W-1:0];
            REG_HOLDOFF: gov_cfg.holdoff_ms  = data[HOLD_W-1:0];
            default: ;
        endcase
    endfunction

    // write every register back to back, junk in the unused data bits, plus one stray index
    task automatic program_regs(input t_cfg c);
        logic [IDX_W-1:0]  idx_q [$];
        logic [DATA_W-1:0] dat_q [$];
        logic [IDX_W-1:0]  stray;
        int k;
        stray = IDX_W'($urandom_range(N_REGS, (1 << IDX_W) - 1));
        idx_q = '{REG_TARGET, REG_HYST, REG_MAXMULT, REG_MINMULT, REG_HOLDOFF, stray};
        dat_q = '{{8'($urandom), c.target_temp},
                  {11'($urandom), c.hysteresis},
                  {9'($urandom), c.max_mult},
                  {9'($urandom), c.min_mult},
                  c.holdoff_ms,
                  16'($urandom)};
        for (k = 0; k < idx_q.size(); k++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx_q[k];
            cfg_if.data  <= dat_q[k];
            do @(posedge i_clk); while (!cfg_if.ready);
            apply_reg_write(idx_q[k], dat_q[k]);
            n_cfg_writes++;
        end
        cfg_if.valid <= 1'b0;
    endtask

    // offer one reading and log its expected result once the transaction happens
    task automatic offer_reading(input logic [CODE_W-1:0] code,
                                 input logic [MULT_W-1:0] mult,
                                 input logic [TIME_W-1:0] now,
                                 input bit use_typed,
                                 input t_result typed);
        t_result exp;
        int gap;
        if (n_sent % 50 == 0)
            send_quiet = ($urandom_range(0, 3) == 0);
        gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.sensor_code  <= code;
        in_if.current_mult <= mult;
        in_if.now_ms       <= now;
        do @(posedge i_clk); while (!in_if.ready);
        exp = govern_reading(code, mult, now);
        clock_mult = exp.new_mult;
        n_sent++;
        if (!exp.reading_valid)
            n_invalid++;
        if (exp.clock_lowered)
            n_cuts++;
        pending_results.push_back(use_typed ? typed : exp);
    endtask

    // stop offering and let every outstanding result come back
    task automatic settle_pipeline();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // result side: random back-pressure, one long hold-off, field checks
    initial begin
        t_result got;
        t_result exp;
        int gap;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (n_taken % 40 == 0)
                take_quiet = ($urandom_range(0, 3) == 0);
            if (n_taken == STALL_AT)
                gap = STALL_CYCLES;
            else
                gap = take_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            got.temp_c        = out_if.temp_c;
            got.reading_valid = out_if.reading_valid;
            got.new_mult      = out_if.new_mult;
            got.clock_lowered = out_if.clock_lowered;
            got.cool_max_mult = out_if.cool_max_mult;
            n_taken++;
            if (pending_results.size() == 0) begin
                $error("result transaction with no reading outstanding");
                n_errors++;
            end else begin
                exp = pending_results.pop_front();
                if (got.temp_c !== exp.temp_c) begin
                    $error("temp_c expected %0d got %0d", exp.temp_c, got.temp_c);
                    n_errors++;
                end
                if (got.reading_valid !== exp.reading_valid) begin
                    $error("reading_valid expected %0d got %0d",
                           exp.reading_valid, got.reading_valid);
                    n_errors++;
                end
                if (got.new_mult !== exp.new_mult) begin
                    $error("new_mult expected %0d got %0d", exp.new_mult, got.new_mult);
                    n_errors++;
                end
                if (got.clock_lowered !== exp.clock_lowered) begin
                    $error("clock_lowered expected %0d got %0d",
                           exp.clock_lowered, got.clock_lowered);
                    n_errors++;
                end
                if (got.cool_max_mult !== exp.cool_max_mult) begin
                    $error("cool_max_mult expected %0d got %0d",
                           exp.cool_max_mult, got.cool_max_mult);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WDOG_LIMIT);
            $display("thermal_clock_governor test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // main sequence
    initial begin
        t_result typed;
        t_cfg    setting;
        int ph;
        int i;
        int r;
        int t;
        int v;
        int tgt;
        int hy;
        logic [CODE_W-1:0] code;
        logic [MULT_W-1:0] mult;

        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.sensor_code  <= '0;
        in_if.current_mult <= '0;
        in_if.now_ms       <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= '0;
        cfg_if.data        <= '0;
        n_sent             = 0;
        n_invalid          = 0;
        n_cuts             = 0;
        n_taken            = 0;
        n_cfg_writes       = 0;
        n_errors           = 0;
        send_quiet         = 1'b0;
        take_quiet         = 1'b0;
        clock_mult         = 7'd100;
        clock_ms           = '0;
        gov_cfg = '{TARGET_RST, HYST_RST, MAXMULT_RST, MINMULT_RST, HOLDOFF_RST};
        gov_st  = '{MAXMULT_RST, '0, 1'b0};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (i = 0; i < N_DIR; i++) begin
            typed.temp_c        = dir_rows[i].temp_c;
            typed.reading_valid = dir_rows[i].reading_valid;
            typed.new_mult      = dir_rows[i].new_mult;
            typed.clock_lowered = dir_rows[i].clock_lowered;
            typed.cool_max_mult = dir_rows[i].cool_max_mult;
            offer_reading(dir_rows[i].code, dir_rows[i].mult, dir_rows[i].now,
                          dir_rows[i].typed_exp, typed);
        end

        // random phases, each under its own register setting
        for (ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) begin
                settle_pipeline();
                case (ph)
                    1: setting = '{8'sd127, 5'd31, 7'd127, 7'd127, 16'hFFFF};
                    2: setting = '{-8'sd128, 5'd0, 7'd1, 7'd1, 16'd0};
                    3: setting = '{8'sd40, 5'd2, 7'd100, 7'd20, 16'd8};
                    4: setting = '{8'sd0, 5'd5, 7'd127, 7'd1, 16'd3};
                    default: begin
                        setting.target_temp = TGT_W'($urandom);
                        setting.hysteresis  = HYST_W'($urandom);
                        setting.max_mult    = MULT_W'($urandom_range(1, 127));
                        setting.min_mult    = MULT_W'($urandom_range(1, 127));
                        setting.holdoff_ms  = ($urandom_range(0, 1) == 0) ?
                                              HOLD_W'($urandom_range(0, 20)) :
                                              HOLD_W'($urandom);
                    end
                endcase
                program_regs(setting);
                if ($urandom_range(0, 2) == 0)
                    clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
            end
            for (i = 0; i < PHASE_ITEMS; i++) begin
                tgt = int'($signed(gov_cfg.target_temp));
                hy  = int'(gov_cfg.hysteresis);
                r   = $urandom_range(0, 99);
                // sensor word: mostly around the target band
                if (r < 65) begin
                    t = tgt - hy - 5 + int'($urandom_range(0, 2 * hy + 10));
                    if (t > 256) t = 256;
                    if (t < -256) t = -256;
                    v = t * 32 - 16 + int'($urandom_range(0, 31));
                    if (v > 8191) v = 8191;
                    if (v < -8192) v = -8192;
                    code = CODE_W'(v * 4 + int'($urandom_range(0, 3)));
                end else if (r < 80) begin
                    code = CODE_W'($urandom);
                end else if (r < 88) begin
                    code = $urandom_range(0, 1) ? CODE_ALL_ONES : CODE_ZERO;
                end else begin
                    case ($urandom_range(0, 3))
                        0: code = 16'h7FFC | 16'($urandom_range(0, 3));
                        1: code = 16'h8000 | 16'($urandom_range(0, 3));
                        2: code = 16'h0001;
                        default: code = 16'hFFFE;
                    endcase
                end
                // multiplier: mostly fed back from the last decision
                r = $urandom_range(0, 99);
                if (r < 55)
                    mult = clock_mult;
                else if (r < 75)
                    mult = gov_st.cool_ceiling;
                else if (r < 78)
                    mult = $urandom_range(0, 1) ? 7'd127 : 7'd1;
                else
                    mult = MULT_W'($urandom_range(1, 127));
                if (mult == 0)
                    mult = 7'd1;
                // time: small steps, steps around the hold-off, rare jumps
                r = $urandom_range(0, 99);
                if (r < 50)
                    clock_ms = clock_ms + $urandom_range(0, 3);
                else if (r < 80)
                    clock_ms = clock_ms + $urandom_range(0, gov_cfg.holdoff_ms + 2);
                else if (r < 95)
                    clock_ms = clock_ms + $urandom_range(0, 131071);
                else
                    clock_ms = $urandom;
                offer_reading(code, mult, clock_ms, 1'b0, '0);
            end
        end

        settle_pipeline();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d readings (%0d invalid, %0d thermal cuts) over %0d settings",
                 n_sent, n_invalid, n_cuts, N_PHASES);
        $display("%0d register writes, %0d results compared, %0d mismatches",
                 n_cfg_writes, n_taken, n_errors);
        if (n_errors == 0)
            $display("thermal_clock_governor test passed");
        else
            $display("thermal_clock_governor test failed");
        $finish;
    end

endmodule
